// File: hdl/xcpd_pkg.sv
// xcpd_pkg: shared types and codes for the xor checked packet deframer
// no dependencies; imported by xcpd_parser, xcpd_out_reg and the top level
package xcpd_pkg;

    // frame parse phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // frame status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_NOSOF  = 2'd2;
    localparam logic [1:0] ST_BADSUM = 2'd3;

    // item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // header byte positions
    localparam logic [2:0] POS_SOF    = 3'd0;
    localparam logic [2:0] POS_CMD    = 3'd1;
    localparam logic [2:0] POS_ADDR_H = 3'd2;
    localparam logic [2:0] POS_ADDR_L = 3'd3;
    localparam logic [2:0] POS_LEN_H  = 3'd4;
    localparam logic [2:0] POS_LEN_L  = 3'd5;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;

    // one result item
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        logic [15:0] address;
        logic [15:0] length;
        logic [1:0]  status;
        logic        frame_last;
    } result_t;

endpackage

// File: hdl/xcpd_parser.sv
// xcpd_parser: frame state and per-byte parse logic, at most one item per advance
// depends on xcpd_pkg
module xcpd_parser
    import xcpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       advance,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       has_result,
    output result_t    result
);

    logic [7:0]  start_byte_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic        bad_reg, bad_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  sum_reg, sum_next;
    logic        done_reg, done_next;
    logic        emit_status;
    logic        emit_payload;
    logic        clear;
    logic [1:0]  st_code;

    // per-byte parse
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        bad_next     = bad_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        done_next    = done_reg;
        emit_status  = 1'b0;
        emit_payload = 1'b0;
        clear        = 1'b0;
        st_code      = ST_OK;
        if (done_reg) begin
            clear = in_last;
        end else if (phase_reg != PH_BODY) begin
            case (pos_reg)
                POS_SOF:    bad_next = (in_byte != start_byte_reg);
                POS_CMD:    cmd_next = in_byte;
                POS_ADDR_H: addr_next = {in_byte, addr_reg[7:0]};
                POS_ADDR_L: addr_next = {addr_reg[15:8], in_byte};
                POS_LEN_H:  len_next = {in_byte, len_reg[7:0]};
                default:    len_next = {len_reg[15:8], in_byte};
            endcase
            if (pos_reg != POS_SOF) begin
                sum_next = sum_reg ^ in_byte;
            end
            pos_next   = pos_reg + 3'd1;
            phase_next = (pos_reg >= POS_LEN_L) ? PH_BODY : PH_HEAD;
            if (in_last) begin
                emit_status = 1'b1;
                st_code     = ST_SHORT;
                clear       = 1'b1;
            end
        end else if (bad_reg) begin
            emit_status = 1'b1;
            st_code     = ST_NOSOF;
            clear       = in_last;
            done_next   = 1'b1;
        end else if (cnt_reg < len_reg) begin
            sum_next = sum_reg ^ in_byte;
            cnt_next = cnt_reg + 16'd1;
            if (in_last) begin
                emit_status = 1'b1;
                st_code     = ST_SHORT;
                clear       = 1'b1;
            end else begin
                emit_payload = 1'b1;
            end
        end else begin
            emit_status = 1'b1;
            st_code     = (in_byte == sum_reg) ? ST_OK : ST_BADSUM;
            clear       = in_last;
            done_next   = 1'b1;
        end
    end

    // result item, status fields taken after this byte's header update
    always_comb begin
        result     = '0;
        has_result = emit_status | emit_payload;
        if (emit_status) begin
            result.item_kind  = KIND_STATUS;
            result.command    = cmd_next;
            result.address    = addr_next;
            result.length     = len_next;
            result.status     = st_code;
            result.frame_last = 1'b1;
        end else begin
            result.item_kind    = KIND_PAYLOAD;
            result.payload_byte = in_byte;
        end
    end

    // start byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RESET;
        end else if (cfg_we) begin
            start_byte_reg <= cfg_wdata;
        end
    end

    // frame state, cleared at the end of each buffer
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && clear)) begin
            phase_reg <= PH_WAIT;
            pos_reg   <= POS_SOF;
            bad_reg   <= 1'b0;
            cmd_reg   <= '0;
            addr_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            bad_reg   <= bad_next;
            cmd_reg   <= cmd_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: hdl/xcpd_out_reg.sv
// xcpd_out_reg: result register driving the master-side stream
// depends on xcpd_pkg
module xcpd_out_reg
    import xcpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        has_result,
    input  result_t     result,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // slot can take a new item when empty or draining this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        if (advance) begin
            valid_next = has_result;
        end else begin
            valid_next = valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds while stalled
    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.item_kind;
    assign m_tlast  = data_reg.frame_last;
    assign m_tdata  = {6'b0, data_reg.status, data_reg.length, data_reg.address,
                       data_reg.command, data_reg.payload_byte};

endmodule

// File: hdl/xor_checked_packet_deframer.sv
// xor_checked_packet_deframer: top level, input register, parser and result register
// depends on xcpd_pkg, xcpd_parser, xcpd_out_reg
//
// Usage:
//   s_ channel carries one buffer byte per item in s_tdata, s_tlast marks the
//   final byte of the buffer. A frame is start byte, command, address (2 bytes,
//   big-endian), length (2 bytes, big-endian), payload, XOR check byte.
//   m_ channel gives payload bytes (m_tuser 0) as they arrive, then one status
//   item (m_tuser 1, m_tlast 1) with command, address, length and status.
//   Bytes after a status give no item until the buffer ends.
//   cfg_we/cfg_wdata write the expected start byte, used at the next first byte.
// Path: an accepted item sits in the input register, is parsed and lands in
//   the result register, which drives m_.
// Throughput: one item per cycle unless stalled; the parse step is a compare,
//   an XOR and a 16-bit count update between the two registers.
// Reset: aresetn low clears both stages, the frame state and sets the start
//   byte to 0xAA.
// Stall: while m_tready is low the result holds; one more item waits in the
//   input register, then s_tready drops until the result is taken.
module xor_checked_packet_deframer
    import xcpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // payload_byte, command, address, length, status, zero pad
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // frame_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    logic       out_free;
    logic       has_result;
    result_t    result;

    // input stage moves into the parser when the result slot is free
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    xcpd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .advance    (advance),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .has_result (has_result),
        .result     (result)
    );

    xcpd_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .has_result (has_result),
        .result     (result),
        .free       (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
